FILE: rtl/amsd_pkg.sv
// Shared types and constants for the admittance mass-spring-damper step unit.
// Used by amsd_cfg, amsd_mul and the top level; depends on nothing else.
package amsd_pkg;

  // Fixed-point format: signed Q16.16 values, unsigned Q16.16 coefficients.
  localparam int unsigned QFrac    = 16;
  localparam int unsigned QWidth   = 32;
  localparam int unsigned DtWidth  = 16;
  localparam int unsigned MulWidth = 32;
  localparam int unsigned ProdWidth = 2 * MulWidth;

  // The net force stays below 2^49 in magnitude, so 50 signed bits hold it.
  localparam int unsigned NetWidth = 50;
  // Acceleration product: 49-bit magnitude times a 32-bit coefficient.
  localparam int unsigned WideWidth = 81;

  // Operation selector carried in the input tuser.
  localparam logic OpStep  = 1'b0;
  localparam logic OpClear = 1'b1;

  // Status codes carried in the output tuser.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadDt    = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CfgInverseMass = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDamping     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgStiffness   = 2'd2;

  // Configuration register contents handed to the datapath.
  typedef struct packed {
    logic [QWidth-1:0] inverse_mass;
    logic [QWidth-1:0] damping;
    logic [QWidth-1:0] stiffness;
  } amsd_cfg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DAMP,
    ST_MUL_STIFF,
    ST_ADD_STIFF,
    ST_ACC_LO,
    ST_ACC_HI,
    ST_ACC_SUM,
    ST_VEL_MUL,
    ST_VEL_ADD,
    ST_POS_MUL,
    ST_POS_ADD,
    ST_DONE
  } amsd_state_e;

endpackage

FILE: rtl/amsd_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on amsd_pkg for the operand and product widths.
module amsd_mul
  import amsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic [MulWidth-1:0]  op_a_i,
  input  logic [MulWidth-1:0]  op_b_i,
  output logic [ProdWidth-1:0] prod_o
);

  logic [ProdWidth-1:0] prod_q;
  logic [ProdWidth-1:0] prod_d;

  // The product is registered before any use.
  assign prod_d = ProdWidth'(op_a_i) * ProdWidth'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/amsd_cfg.sv
// Configuration register file for inverse mass, damping and stiffness.
// Depends on amsd_pkg for the register indexes and the amsd_cfg_t struct.
module amsd_cfg
  import amsd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [CfgIdxWidth-1:0] wr_index_i,
  input  logic [QWidth-1:0]      wr_data_i,
  output amsd_cfg_t              cfg_o
);

  amsd_cfg_t cfg_q;
  amsd_cfg_t cfg_d;

  // Decode the register index; unknown indexes leave everything as is.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CfgInverseMass: cfg_d.inverse_mass = wr_data_i;
        CfgDamping:     cfg_d.damping      = wr_data_i;
        CfgStiffness:   cfg_d.stiffness    = wr_data_i;
        default:        cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inverse_mass <= QWidth'(32'h0001_0000);
      cfg_q.damping      <= '0;
      cfg_q.stiffness    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/admittance_mass_spring_damper_step_unit.sv
// Top level of the single-axis admittance filter step unit (semi-implicit Euler, Q16.16).
// Depends on amsd_pkg, amsd_cfg (coefficient registers) and amsd_mul (shared multiplier).
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/s_axis_tready tdata {time_step, applied_force}, tuser op
//   m_axis    out        m_axis_tvalid/m_axis_tready tdata {accel, velocity, position}, tuser status
//   cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// From acceptance until the unit is ready again, an integrate request runs through six
// passes of the one shared 32x32 multiplier and the adds between them. A clear or zero
// time step goes straight to the final state; an acceleration or velocity overflow ends the run after its check.
// After reset the state is zero and inverse mass is 1.0; no clearing pass is needed.
// The result waits in an output register; the next request is taken while it waits, and
// the unit stalls in its final state only if that register is still full.
module admittance_mass_spring_damper_step_unit
  import amsd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,  // [31:0] applied_force, [47:32] time_step
  input  logic [0:0]             s_axis_tuser,  // [0] op
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [95:0]            m_axis_tdata,  // [31:0] position_out, [63:32] velocity_out,
                                                // [95:64] acceleration_out
  output logic [1:0]             m_axis_tuser,  // [1:0] status
  // Configuration writes.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [QWidth-1:0]      cfg_data_i
);

  amsd_cfg_t cfg;

  amsd_state_e state_q, state_d;

  // Integrator state.
  logic signed [QWidth-1:0]   pos_q, pos_d;
  logic signed [QWidth-1:0]   vel_q, vel_d;
  logic signed [QWidth-1:0]   acc_q, acc_d;

  // Working registers of one request.
  logic signed [NetWidth-1:0] net_q, net_d;
  logic [WideWidth-1:0]       wide_q, wide_d;
  logic signed [QWidth-1:0]   acc_n_q, acc_n_d;
  logic signed [QWidth-1:0]   vel_n_q, vel_n_d;
  logic [DtWidth-1:0]         dt_q, dt_d;
  logic [1:0]                 status_q, status_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [95:0]                out_data_q, out_data_d;
  logic [1:0]                 out_user_q, out_user_d;

  // Sequencer outputs.
  logic [MulWidth-1:0]        mul_a, mul_b;
  logic                       in_ready;
  logic                       out_load;

  // Shared unit results and helpers.
  logic [ProdWidth-1:0]       prod;
  logic [ProdWidth:0]         prod_rnd_sum;
  logic [ProdWidth-QFrac:0]   prod_rnd;
  logic [NetWidth-1:0]        net_abs;
  logic [WideWidth-1:0]       acc_full;
  logic [WideWidth-QFrac-1:0] acc_mag;
  logic                       acc_ovf;
  logic signed [QWidth+2:0]   vel_sum;
  logic signed [QWidth+2:0]   pos_sum;
  logic                       vel_ovf;
  logic                       pos_ovf;
  logic                       in_accept;
  logic                       in_op;
  logic signed [QWidth-1:0]   in_force;
  logic [DtWidth-1:0]         in_dt;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_op     = s_axis_tuser[0];
  assign in_force  = s_axis_tdata[QWidth-1:0];
  assign in_dt     = s_axis_tdata[QWidth+DtWidth-1:QWidth];

  // Coefficient registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  amsd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  amsd_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // Round the registered product to nearest at 2^-16, ties away from zero on magnitude.
  assign prod_rnd_sum = {1'b0, prod} + (ProdWidth+1)'(1 << (QFrac - 1));
  assign prod_rnd     = prod_rnd_sum[ProdWidth:QFrac];

  // Magnitude of the net force; it is split into a low and a high multiplier pass.
  assign net_abs = net_q[NetWidth-1] ? NetWidth'(-net_q) : NetWidth'(net_q);

  // Acceleration: combine the two partial products, rounding bias already in wide_q.
  assign acc_full = wide_q + {prod[WideWidth-MulWidth-1:0], {MulWidth{1'b0}}};
  assign acc_mag  = acc_full[WideWidth-1:QFrac];
  assign acc_ovf  = (|acc_mag[WideWidth-QFrac-1:QWidth]) ||
                    (net_q[NetWidth-1] ? (acc_mag[QWidth-1:0] > 32'h8000_0000)
                                       : acc_mag[QWidth-1]);

  // Velocity and position updates with a signed range check.
  assign vel_sum = acc_n_q[QWidth-1]
                 ? (QWidth+3)'(vel_q) - $signed({2'b00, prod_rnd[QWidth:0]})
                 : (QWidth+3)'(vel_q) + $signed({2'b00, prod_rnd[QWidth:0]});
  assign pos_sum = vel_n_q[QWidth-1]
                 ? (QWidth+3)'(pos_q) - $signed({2'b00, prod_rnd[QWidth:0]})
                 : (QWidth+3)'(pos_q) + $signed({2'b00, prod_rnd[QWidth:0]});
  assign vel_ovf = (vel_sum[QWidth+2:QWidth-1] != '0) && (vel_sum[QWidth+2:QWidth-1] != '1);
  assign pos_ovf = (pos_sum[QWidth+2:QWidth-1] != '0) && (pos_sum[QWidth+2:QWidth-1] != '1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_op == OpClear || in_dt == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL_DAMP;
          end
        end
      end
      ST_MUL_DAMP:  state_d = ST_MUL_STIFF;
      ST_MUL_STIFF: state_d = ST_ADD_STIFF;
      ST_ADD_STIFF: state_d = ST_ACC_LO;
      ST_ACC_LO:    state_d = ST_ACC_HI;
      ST_ACC_HI:    state_d = ST_ACC_SUM;
      ST_ACC_SUM:   state_d = acc_ovf ? ST_DONE : ST_VEL_MUL;
      ST_VEL_MUL:   state_d = ST_VEL_ADD;
      ST_VEL_ADD:   state_d = vel_ovf ? ST_DONE : ST_POS_MUL;
      ST_POS_MUL:   state_d = ST_POS_ADD;
      ST_POS_ADD:   state_d = ST_DONE;
      ST_DONE:      state_d = out_load ? ST_IDLE : ST_DONE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operand select and handshake control.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL_DAMP: begin
        mul_a = vel_q[QWidth-1] ? MulWidth'(-vel_q) : MulWidth'(vel_q);
        mul_b = cfg.damping;
      end
      ST_MUL_STIFF: begin
        mul_a = pos_q[QWidth-1] ? MulWidth'(-pos_q) : MulWidth'(pos_q);
        mul_b = cfg.stiffness;
      end
      ST_ACC_LO: begin
        mul_a = net_abs[MulWidth-1:0];
        mul_b = cfg.inverse_mass;
      end
      ST_ACC_HI: begin
        mul_a = MulWidth'(net_abs[NetWidth-1:MulWidth]);
        mul_b = cfg.inverse_mass;
      end
      ST_VEL_MUL: begin
        mul_a = acc_n_q[QWidth-1] ? MulWidth'(-acc_n_q) : MulWidth'(acc_n_q);
        mul_b = MulWidth'(dt_q);
      end
      ST_POS_MUL: begin
        mul_a = vel_n_q[QWidth-1] ? MulWidth'(-vel_n_q) : MulWidth'(vel_n_q);
        mul_b = MulWidth'(dt_q);
      end
      ST_DONE: out_load = !out_valid_q || m_axis_tready;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign s_axis_tready = in_ready;

  // Datapath register updates, stepped by the sequencer state.
  always_comb begin
    pos_d    = pos_q;
    vel_d    = vel_q;
    acc_d    = acc_q;
    net_d    = net_q;
    wide_d   = wide_q;
    acc_n_d  = acc_n_q;
    vel_n_d  = vel_n_q;
    dt_d     = dt_q;
    status_d = status_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          dt_d     = in_dt;
          net_d    = NetWidth'(in_force);
          status_d = StatusOk;
          if (in_op == OpClear) begin
            pos_d = '0;
            vel_d = '0;
            acc_d = '0;
          end else if (in_dt == '0) begin
            status_d = StatusBadDt;
          end
        end
      end
      ST_MUL_STIFF: begin
        // Damping term, sign taken from the velocity.
        net_d = vel_q[QWidth-1] ? net_q + $signed({1'b0, prod_rnd[NetWidth-2:0]})
                                : net_q - $signed({1'b0, prod_rnd[NetWidth-2:0]});
      end
      ST_ADD_STIFF: begin
        // Spring term, sign taken from the position.
        net_d = pos_q[QWidth-1] ? net_q + $signed({1'b0, prod_rnd[NetWidth-2:0]})
                                : net_q - $signed({1'b0, prod_rnd[NetWidth-2:0]});
      end
      ST_ACC_HI: begin
        // Low partial product plus the rounding bias.
        wide_d = WideWidth'(prod) + WideWidth'(1 << (QFrac - 1));
      end
      ST_ACC_SUM: begin
        if (acc_ovf) begin
          status_d = StatusOverflow;
        end else begin
          acc_n_d = net_q[NetWidth-1] ? QWidth'(-acc_mag[QWidth-1:0])
                                      : QWidth'(acc_mag[QWidth-1:0]);
        end
      end
      ST_VEL_ADD: begin
        if (vel_ovf) begin
          status_d = StatusOverflow;
        end else begin
          vel_n_d = vel_sum[QWidth-1:0];
        end
      end
      ST_POS_ADD: begin
        // Commit the new state only when the position also fits.
        if (pos_ovf) begin
          status_d = StatusOverflow;
        end else begin
          pos_d = pos_sum[QWidth-1:0];
          vel_d = vel_n_q;
          acc_d = acc_n_q;
        end
      end
      default: begin
        net_d = net_q;
      end
    endcase
  end

  // Output register: loaded from the kept or committed state in the final state.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {acc_q, vel_q, pos_q};
      out_user_d  = status_q;
    end else if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    net_q      <= net_d;
    wide_q     <= wide_d;
    acc_n_q    <= acc_n_d;
    vel_n_q    <= vel_n_d;
    dt_q       <= dt_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The position changes only on a clear or on a successful commit.
  a_pos_commit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_POS_ADD && !(in_accept && in_op == OpClear)) |=> $stable(pos_q))
    else $error("position changed outside commit or clear");

  // A delivered status is always one of the defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == StatusOk || m_axis_tuser == StatusBadDt ||
                       m_axis_tuser == StatusOverflow))
    else $error("undefined status on output");

  // With zero inverse mass a committed step leaves zero acceleration.
  a_zero_inv_mass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POS_ADD && !pos_ovf && cfg.inverse_mass == '0) |=> (acc_q == '0))
    else $error("nonzero acceleration with zero inverse mass");

  // An accepted request always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

endmodule

FILE: verif/admittance_mass_spring_damper_step_unit_tb.sv
// Self-checking testbench for the admittance mass-spring-damper step unit.
// Depends on amsd_pkg and the RTL of admittance_mass_spring_damper_step_unit.
// A directed table runs first, then random requests under four pacing modes.
module admittance_mass_spring_damper_step_unit_tb
  import amsd_pkg::*;
();

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 200;
  // Margin left after the last result has been collected.
  localparam int DrainCycles   = 16;
  localparam longint QMax      = 64'sh0000_0000_7FFF_FFFF;
  localparam longint QMin      = -QMax - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
  } motion_result_t;

  typedef enum logic {RowRequest, RowRegister} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic                   op;
    logic [31:0]            ext_force;
    logic [15:0]            dt;
    logic [CfgIdxWidth-1:0] reg_index;
    logic [31:0]            reg_value;
    logic                   known;
    motion_result_t         want;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata;   // [31:0] applied_force, [47:32] time_step
  logic [0:0]             s_axis_tuser;   // [0] op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [95:0]            m_axis_tdata;   // [31:0] position, [63:32] velocity, [95:64] accel
  logic [1:0]             m_axis_tuser;   // [1:0] status
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [QWidth-1:0]      cfg_data_i;

  // Predicted filter state and coefficient copies.
  longint      tracked_pos;
  longint      tracked_vel;
  longint      tracked_acc;
  logic [31:0] coef_inv_mass;
  logic [31:0] coef_damping;
  logic [31:0] coef_stiffness;

  motion_result_t pending_results[$];
  stim_row_t      directed_rows[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int error_count    = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int clear_requests = 0;
  int register_writes = 0;

  admittance_mass_spring_damper_step_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Product of a signed value and an unsigned Q16.16 factor, scaled by 2^-16.
  // The magnitude rounds half away from zero and saturates at 2^49.
  function automatic longint q16_product(longint a, logic [31:0] b);
    longint unsigned m, hi, lo, mag;
    logic neg;
    neg = a < 0;
    m   = neg ? -a : a;
    hi  = (m >> 32) * b;
    lo  = (m & 64'hFFFF_FFFF) * b;
    if (hi >= 64'h1_0000_0000) begin
      mag = 64'd1 << 49;
    end else begin
      mag = (hi << 16) + ((lo + 64'h8000) >> 16);
      if (mag > (64'd1 << 49)) mag = 64'd1 << 49;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic fits_q16(longint v);
    return v >= QMin && v <= QMax;
  endfunction

  // One semi-implicit Euler step; the state only moves when all three values fit.
  function automatic motion_result_t integrate_step(logic op, logic signed [31:0] ext_force,
                                                    logic [15:0] dt);
    longint net, a, v, p;
    motion_result_t r;
    r.status = StatusOk;
    if (op == OpClear) begin
      tracked_pos = 0;
      tracked_vel = 0;
      tracked_acc = 0;
    end else if (dt == '0) begin
      r.status = StatusBadDt;
    end else begin
      net = longint'(ext_force) - q16_product(tracked_vel, coef_damping)
            - q16_product(tracked_pos, coef_stiffness);
      a = q16_product(net, coef_inv_mass);
      v = tracked_vel + q16_product(a, {16'h0, dt});
      p = tracked_pos + q16_product(v, {16'h0, dt});
      if (fits_q16(a) && fits_q16(v) && fits_q16(p)) begin
        tracked_pos = p;
        tracked_vel = v;
        tracked_acc = a;
      end else begin
        r.status = StatusOverflow;
      end
    end
    r.position     = tracked_pos[31:0];
    r.velocity     = tracked_vel[31:0];
    r.acceleration = tracked_acc[31:0];
    return r;
  endfunction

  // Table row builders.
  function automatic stim_row_t request_row(logic op, logic [31:0] f, logic [15:0] dt);
    return '{RowRequest, op, f, dt, '0, '0, 1'b0, '0};
  endfunction

  function automatic stim_row_t known_row(logic op, logic [31:0] f, logic [15:0] dt,
                                          logic [1:0] st, logic [31:0] p, logic [31:0] v,
                                          logic [31:0] a);
    motion_result_t w;
    w = '{st, p, v, a};
    return '{RowRequest, op, f, dt, '0, '0, 1'b1, w};
  endfunction

  function automatic stim_row_t register_row(logic [CfgIdxWidth-1:0] idx, logic [31:0] val);
    return '{RowRegister, OpStep, '0, '0, idx, val, 1'b0, '0};
  endfunction

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register writes happen only with the unit idle and every result collected.
  task automatic write_register(logic [CfgIdxWidth-1:0] idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgInverseMass: coef_inv_mass  = val;
      CfgDamping:     coef_damping   = val;
      CfgStiffness:   coef_stiffness = val;
      default: ;
    endcase
    register_writes++;
  endtask

  // Present one request after a random gap and record its expected result once accepted.
  task automatic send_request(logic op, logic [31:0] ext_force, logic [15:0] dt,
                              logic known, motion_result_t want);
    motion_result_t predicted;
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, ext_force};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = integrate_step(op, ext_force, dt);
    pending_results.push_back(known ? want : predicted);
    if (op == OpClear) clear_requests++;
  endtask

  // Compare an accepted result with the oldest outstanding expectation.
  task automatic check_result();
    motion_result_t want;
    if (pending_results.size() == 0) begin
      $error("Result with no request outstanding, status %0d", m_axis_tuser);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      status_seen[want.status]++;
      if (m_axis_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        error_count++;
      end
      if (m_axis_tdata[31:0] !== want.position) begin
        $error("position_out: expected %0d, got %0d",
               $signed(want.position), $signed(m_axis_tdata[31:0]));
        error_count++;
      end
      if (m_axis_tdata[63:32] !== want.velocity) begin
        $error("velocity_out: expected %0d, got %0d",
               $signed(want.velocity), $signed(m_axis_tdata[63:32]));
        error_count++;
      end
      if (m_axis_tdata[95:64] !== want.acceleration) begin
        $error("acceleration_out: expected %0d, got %0d",
               $signed(want.acceleration), $signed(m_axis_tdata[95:64]));
        error_count++;
      end
    end
  endtask

  // Output side: check on each handshake and stall at random.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result();
    m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Main stimulus.
  initial begin
    int          phase;
    int          n;
    int          roll;
    logic        op;
    logic [31:0] f;
    logic [15:0] dt;
    logic [31:0] inv;
    logic [31:0] dmp;
    logic [31:0] stf;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    tracked_pos    = 0;
    tracked_vel    = 0;
    tracked_acc    = 0;
    coef_inv_mass  = 32'h0001_0000;
    coef_damping   = '0;
    coef_stiffness = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, clears, bad time step and each kind of overflow.
    directed_rows = '{
      known_row(OpClear, 32'h0, 16'h0, StatusOk, '0, '0, '0),
      known_row(OpStep, 32'h7FFF_FFFF, 16'h0, StatusBadDt, '0, '0, '0),
      known_row(OpStep, 32'h0, 16'h1, StatusOk, '0, '0, '0),
      request_row(OpStep, 32'h7FFF_FFFF, 16'hFFFF),
      // Second full-scale push drives velocity out of range.
      request_row(OpStep, 32'h7FFF_FFFF, 16'hFFFF),
      request_row(OpStep, 32'h8000_0000, 16'h0),
      // A clear ignores its force and time step.
      known_row(OpClear, 32'h7FFF_FFFF, 16'hFFFF, StatusOk, '0, '0, '0),
      request_row(OpStep, 32'h8000_0000, 16'h1),
      request_row(OpStep, 32'h0000_0001, 16'h8000),
      known_row(OpClear, 32'h8000_0000, 16'h0, StatusOk, '0, '0, '0),
      request_row(OpStep, 32'h7FFF_0000, 16'hFFFF),
      // Coasting at near full velocity pushes position out of range.
      request_row(OpStep, 32'h0, 16'hFFFF),
      known_row(OpClear, 32'h0, 16'h0, StatusOk, '0, '0, '0),
      register_row(CfgInverseMass, 32'hFFFF_FFFF),
      // Largest mass gain on the largest force overflows the acceleration.
      known_row(OpStep, 32'h7FFF_FFFF, 16'h1, StatusOverflow, '0, '0, '0),
      request_row(OpStep, 32'hFFFF_FFFF, 16'h1),
      // Zero inverse mass is legal and keeps the acceleration at zero.
      register_row(CfgInverseMass, 32'h0),
      request_row(OpStep, 32'h7FFF_FFFF, 16'hFFFF),
      register_row(CfgInverseMass, 32'h1),
      register_row(CfgDamping, 32'hFFFF_FFFF),
      register_row(CfgStiffness, 32'hFFFF_FFFF),
      request_row(OpStep, 32'h8000_0000, 16'hFFFF),
      request_row(OpStep, 32'h7FFF_FFFF, 16'hFFFF),
      request_row(OpStep, 32'h0, 16'h0100)
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowRegister) begin
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].ext_force, directed_rows[i].dt,
                     directed_rows[i].known, directed_rows[i].want);
      end
    end

    // Random part: one coefficient set and one pacing mode per phase.
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin inv = 32'h0001_0000; dmp = 32'h0;         stf = 32'h0;         end
        1: begin inv = 32'h0001_0000; dmp = 32'h0000_8000; stf = 32'h0001_0000; end
        2: begin inv = 32'h0000_4000; dmp = 32'h0002_0000; stf = 32'h0004_0000; end
        3: begin inv = 32'hFFFF_FFFF; dmp = 32'hFFFF_FFFF; stf = 32'hFFFF_FFFF; end
        4: begin inv = 32'h1;         dmp = 32'h0;         stf = 32'h0;         end
        5: begin
          inv = $urandom_range(1, 32'h0004_0000);
          dmp = $urandom_range(0, 32'h0008_0000);
          stf = $urandom_range(0, 32'h0008_0000);
        end
        6: begin inv = 32'h0001_0000; dmp = 32'hFFFF_FFFF; stf = 32'h0;         end
        default: begin inv = $urandom; dmp = $urandom; stf = $urandom; end
      endcase
      write_register(CfgInverseMass, inv);
      write_register(CfgDamping, dmp);
      write_register(CfgStiffness, stf);
      case (phase % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      for (n = 0; n < ItemsPerPhase; n++) begin
        // Hold off once until the unit has handed back everything.
        if (phase == 1 && n == ItemsPerPhase / 2) begin
          s_axis_tvalid <= 1'b0;
          wait_for_results();
        end
        // Mostly short stepping runs between clears, with some full-range noise.
        roll = $urandom_range(0, 99);
        op   = OpStep;
        f    = $urandom;
        dt   = 16'($urandom_range(1, 16'h0800));
        if (roll < 7) begin
          op = OpClear;
        end else if (roll < 10) begin
          dt = '0;
        end else if (roll < 16) begin
          dt = 16'($urandom);
        end else begin
          f = 32'($signed(f) >>> $urandom_range(8, 31));
        end
        send_request(op, f, dt, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_for_results();
    $display("Checked %0d results: %0d ok, %0d bad time step, %0d overflow, %0d clears.",
             status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
             status_seen[StatusOk], status_seen[StatusBadDt], status_seen[StatusOverflow],
             clear_requests);
    $display("Used %0d register writes across %0d random coefficient phases and four pacings.",
             register_writes, NumPhases);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $error("Run did not finish in time, %0d results outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
